// File: hw/rtl/rth_pkg.sv
// Package for the RGB to HSL converter: widths, base codes and the
// record that travels down the divider chain. No dependencies.
`timescale 1ns / 1ps

package rth_pkg;

  localparam int unsigned CH_BITS    = 8;
  localparam int unsigned LIGHT_W    = CH_BITS + 1;
  localparam int unsigned REM_W      = CH_BITS + 1;
  localparam int unsigned HUE_W      = 11;
  localparam int unsigned SAT_W      = 16;
  localparam int unsigned QUO_W      = SAT_W + 1;
  localparam int unsigned NUM_CELLS  = QUO_W;
  localparam int unsigned SEXT_BITS  = 8;
  localparam int unsigned HUE_INT_W  = SEXT_BITS + 1;
  localparam int unsigned HUE_FRAC_W = QUO_W - HUE_INT_W;
  localparam int unsigned BASE_W     = HUE_W - SEXT_BITS;

  localparam logic [BASE_W-1:0] BASE_ONE   = BASE_W'(1);
  localparam logic [BASE_W-1:0] BASE_THREE = BASE_W'(3);
  localparam logic [BASE_W-1:0] BASE_FIVE  = BASE_W'(5);

  localparam logic [CH_BITS-1:0] CH_MAX = '1;

  typedef struct packed {
    logic               gray;
    logic               sub;
    logic [BASE_W-1:0]  base;
    logic [LIGHT_W-1:0] light;
    logic [CH_BITS-1:0] sat_den;
    logic [REM_W-1:0]   sat_rem;
    logic [QUO_W-1:0]   sat_quo;
    logic [CH_BITS-1:0] hue_div;
    logic [REM_W-1:0]   hue_rem;
    logic [QUO_W-1:0]   hue_quo;
  } cell_t;

endpackage

// File: hw/rtl/rth_front.sv
// Input stage: max/min search, sextant choice and divider setup.
// Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [rth_pkg::CH_BITS-1:0] red_i,
  input  logic [rth_pkg::CH_BITS-1:0] green_i,
  input  logic [rth_pkg::CH_BITS-1:0] blue_i,
  output logic                      valid_o,
  output rth_pkg::cell_t            data_o
);
  import rth_pkg::*;

  logic               valid_q;
  cell_t              data_d, data_q;
  logic [CH_BITS-1:0] v, m, vm, num;
  logic [LIGHT_W-1:0] sum, far;

  always_comb begin
    v = red_i;
    m = red_i;
    if (green_i > v) v = green_i;
    if (blue_i > v) v = blue_i;
    if (green_i < m) m = green_i;
    if (blue_i < m) m = blue_i;
    sum = LIGHT_W'(v) + LIGHT_W'(m);
    far = LIGHT_W'({CH_MAX, 1'b0}) - sum;
    vm  = v - m;

    data_d.gray  = (vm == '0);
    data_d.light = sum;
    if (red_i == v) begin
      if (green_i == m) begin
        num = v - blue_i; data_d.base = BASE_FIVE; data_d.sub = 1'b0;
      end else begin
        num = v - green_i; data_d.base = BASE_ONE; data_d.sub = 1'b1;
      end
    end else if (green_i == v) begin
      if (blue_i == m) begin
        num = v - red_i; data_d.base = BASE_ONE; data_d.sub = 1'b0;
      end else begin
        num = v - blue_i; data_d.base = BASE_THREE; data_d.sub = 1'b1;
      end
    end else begin
      if (red_i == m) begin
        num = v - green_i; data_d.base = BASE_THREE; data_d.sub = 1'b0;
      end else begin
        num = v - red_i; data_d.base = BASE_FIVE; data_d.sub = 1'b1;
      end
    end

    data_d.sat_den = (sum <= LIGHT_W'(CH_MAX)) ? sum[CH_BITS-1:0] : far[CH_BITS-1:0];
    data_d.sat_rem = REM_W'(vm);
    data_d.sat_quo = '0;
    data_d.hue_div = vm;
    data_d.hue_rem = REM_W'(num);
    data_d.hue_quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/rth_cell.sv
// One divider cell: a restoring step for the saturation and hue quotients.
// Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  rth_pkg::cell_t data_i,
  output logic           valid_o,
  output rth_pkg::cell_t data_o
);
  import rth_pkg::*;

  logic             valid_q;
  cell_t            data_d, data_q;
  logic             sat_ge, hue_ge;
  logic [REM_W-1:0] sat_diff, hue_diff;

  always_comb begin
    sat_ge   = data_i.sat_rem >= REM_W'(data_i.sat_den);
    hue_ge   = data_i.hue_rem >= REM_W'(data_i.hue_div);
    sat_diff = sat_ge ? data_i.sat_rem - REM_W'(data_i.sat_den) : data_i.sat_rem;
    hue_diff = hue_ge ? data_i.hue_rem - REM_W'(data_i.hue_div) : data_i.hue_rem;

    data_d         = data_i;
    data_d.sat_rem = {sat_diff[REM_W-2:0], 1'b0};
    data_d.hue_rem = {hue_diff[REM_W-2:0], 1'b0};
    data_d.sat_quo = {data_i.sat_quo[QUO_W-2:0], sat_ge};
    data_d.hue_quo = {data_i.hue_quo[QUO_W-2:0], hue_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/rth_back.sv
// Output stage: hue assembly with ceiling on subtraction, saturation clamp,
// and the output register. Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  rth_pkg::cell_t              data_i,
  output logic                        valid_o,
  output logic [rth_pkg::HUE_W-1:0]   hue_o,
  output logic [rth_pkg::SAT_W-1:0]   saturation_o,
  output logic [rth_pkg::LIGHT_W-1:0] lightness_o
);
  import rth_pkg::*;

  logic                 valid_q;
  logic [HUE_W-1:0]     hue_d, hue_q, base_w, q_w;
  logic [SAT_W-1:0]     sat_d, sat_q;
  logic [LIGHT_W-1:0]   light_q;
  logic [HUE_INT_W-1:0] q_int;
  logic                 frac_nz;

  always_comb begin
    q_int   = data_i.hue_quo[QUO_W-1 -: HUE_INT_W];
    frac_nz = (data_i.hue_quo[HUE_FRAC_W-1:0] != '0) || (data_i.hue_rem != '0);
    base_w  = {data_i.base, {SEXT_BITS{1'b0}}};
    q_w     = HUE_W'(q_int);
    if (data_i.gray) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = data_i.sub ? base_w - q_w - HUE_W'(frac_nz) : base_w + q_w;
      sat_d = data_i.sat_quo[QUO_W-1] ? '1 : data_i.sat_quo[SAT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      light_q <= data_i.light;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign lightness_o  = light_q;

endmodule

// File: hw/rtl/rgb_to_hsl.sv
// RGB to HSL converter top level: front stage, chain of divider cells,
// output stage. Depends on rth_pkg, rth_front, rth_cell, rth_back.
// Pipeline: 1 front stage, 17 divider cells and 1 output register lie between
// an accepted input transaction and output valid.
// Throughput: one transaction per cycle; the whole chain holds while the
// output register is full and stalled. Reset clears all valid bits.
`timescale 1ns / 1ps

module rgb_to_hsl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [rth_pkg::CH_BITS-1:0] red_i,
  input  logic [rth_pkg::CH_BITS-1:0] green_i,
  input  logic [rth_pkg::CH_BITS-1:0] blue_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [rth_pkg::HUE_W-1:0]   hue_o,
  output logic [rth_pkg::SAT_W-1:0]   saturation_o,
  output logic [rth_pkg::LIGHT_W-1:0] lightness_o
);
  import rth_pkg::*;

  logic  adv;
  logic  chain_valid [NUM_CELLS+1];
  cell_t chain_data  [NUM_CELLS+1];

  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (chain_valid[0]),
    .data_o  (chain_data[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rth_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  rth_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (chain_valid[NUM_CELLS]),
    .data_i       (chain_data[NUM_CELLS]),
    .valid_o      (valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .lightness_o  (lightness_o)
  );

endmodule
